// ----- rtl/swsnd_pkg.sv -----
// Shared types and constants of the sliding window sender.
package swsnd_pkg;

  localparam int unsigned WINDOW_MAX_DFLT  = 16;
  localparam int unsigned QUEUE_DEPTH_DFLT = 128;
  localparam logic [4:0]  WIN_SIZE_RESET   = 5'd4;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_TX_NEW  = 3'd0,
    ACT_TX_DEQ  = 3'd1,
    ACT_RETX    = 3'd2,
    ACT_QUEUED  = 3'd3,
    ACT_DROPPED = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK_RD,
    ST_ACK_EV,
    ST_TO_RD,
    ST_TO_EV,
    ST_RT_CHK,
    ST_RT_EV,
    ST_FIN
  } state_e;

  // One window slot as held in the slot memory
  typedef struct packed {
    logic [31:0] pidx;
    logic [31:0] exp_ack;
    logic [31:0] seq;
    logic [9:0]  len;
    logic        fin;
  } slot_t;

  // One queued segment
  typedef struct packed {
    logic [9:0] len;
    logic       fin;
  } qent_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] packet_number;
    logic [31:0] byte_seq;
    logic [9:0]  data_len;
    logic        fin_flag;
    logic        restart_timer;
    logic        last;
  } result_t;

endpackage

// ----- rtl/swsnd_in_if.sv -----
// Command channel interface of the sliding window sender.
interface swsnd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  seg_len;
  logic        seg_fin;
  logic [31:0] ack_value;

  modport source (output valid, command, seg_len, seg_fin, ack_value, input ready);
  modport sink   (input valid, command, seg_len, seg_fin, ack_value, output ready);
endinterface

// ----- rtl/swsnd_out_if.sv -----
// Result channel interface of the sliding window sender.
interface swsnd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] packet_number;
  logic [31:0] byte_seq;
  logic [9:0]  data_len;
  logic        fin_flag;
  logic        restart_timer;
  logic        last;

  modport source (output valid, action, packet_number, byte_seq, data_len, fin_flag,
                  restart_timer, last, input ready);
  modport sink   (input valid, action, packet_number, byte_seq, data_len, fin_flag,
                  restart_timer, last, output ready);
endinterface

// ----- rtl/swsnd_ram.sv -----
// Generic simple dual port RAM with registered read.
module swsnd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/sliding_window_sender_top.sv -----
// Top level of the sliding window sender: slot/queue memories and control sequencer.
//
// Usage: commands enter on snd_i (send segment, cumulative ack, retransmit timeout);
// results leave on res_o, the final result of a command carrying last. window_size
// is to be written through cfg_we_i/cfg_wdata_i only while the block is idle;
// the block does not enforce this. One command is handled at a time; snd_i.ready
// is high only between commands. Send: one result, through the result stage to
// the output register; the next command is taken once it leaves the result stage.
// Ack: the sequencer visits every window slot, with a read state and an evaluation
// state per slot for the registered read of the slot memory; the last result is
// moved to the output register in ST_FIN, which waits while the receiver stalls;
// the next command is taken after that.
// Timeout: a pass over all slots maps busy slots to their window position, then
// each position is checked in turn and each mapped one is retransmitted.
// The queue memory is read at its head and gives the segment released by an ack.
// A result stage holds the newest result until the next one or the end of the
// command decides its last and restart_timer bits; an output register parts it
// from the receiver. When the receiver stalls the sequencer holds in place.
// Reset empties the window, queue and counters and sets window_size to 4; the
// memories need no clearing since only busy slots and held queue entries are read.
module sliding_window_sender_top
  import swsnd_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DFLT,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  swsnd_in_if.sink   snd_i,
  swsnd_out_if.source res_o
);

  localparam int unsigned SW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  state_e                 state_q, state_d;
  logic [4:0]             win_reg_q;
  logic [WINDOW_MAX-1:0]  busy_q, busy_d;
  logic [31:0]            base_q, base_d;
  logic [31:0]            next_pidx_q, next_pidx_d;
  logic [31:0]            byte_cnt_q, byte_cnt_d;
  logic [QW-1:0]          q_head_q, q_head_d, q_tail_q, q_tail_d;
  logic [QCW-1:0]         q_count_q, q_count_d;
  logic [9:0]             seg_len_q, seg_len_d;
  logic                   seg_fin_q, seg_fin_d;
  logic [31:0]            ack_q, ack_d;
  logic                   retx_q, retx_d;
  logic [SW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          freed_q, freed_d;
  logic                   pending_q, pending_d;
  logic [WINDOW_MAX-1:0]  map_v_q, map_v_d;
  logic [SW-1:0]          map_slot_q [WINDOW_MAX];
  logic [SW-1:0]          map_slot_d [WINDOW_MAX];
  logic                   rs_valid_q, rs_valid_d;
  result_t                rs_q, rs_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;

  logic [CW-1:0]          ws_eff;
  logic [CW-1:0]          busy_cnt;
  logic [WINDOW_MAX-1:0]  free_mask;
  logic [SW-1:0]          low_free;
  logic                   can_push;
  logic                   last_slot;
  logic                   ack_hit;
  logic                   pend_now;
  logic [31:0]            diff;
  logic [CW-1:0]          freed_n;

  logic                   slot_we;
  logic [SW-1:0]          slot_waddr, slot_raddr;
  slot_t                  slot_wdata, slot_rdata;
  logic                   q_we;
  qent_t                  q_wdata, q_rdata;

  // Slot memory: one entry per window slot
  swsnd_ram #(.WIDTH($bits(slot_t)), .DEPTH(WINDOW_MAX)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Segment queue memory, read at the head
  swsnd_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_tail_q),
    .wdata_i (q_wdata),
    .raddr_i (q_head_q),
    .rdata_o (q_rdata)
  );

  // Clamp the configured window size
  always_comb begin
    if (win_reg_q == 5'd0) begin
      ws_eff = CW'(1);
    end else if (32'(win_reg_q) > 32'(WINDOW_MAX)) begin
      ws_eff = CW'(WINDOW_MAX);
    end else begin
      ws_eff = CW'(win_reg_q);
    end
  end

  // Count busy slots and find the lowest free one
  always_comb begin
    busy_cnt = '0;
    for (int k = 0; k < WINDOW_MAX; k++) begin
      busy_cnt = busy_cnt + CW'(busy_q[k]);
    end
    free_mask = ~busy_q;
    if (state_q == ST_ACK_EV) begin
      free_mask[idx_q] = 1'b1;
    end
    low_free = '0;
    for (int k = WINDOW_MAX - 1; k >= 0; k--) begin
      if (free_mask[k]) begin
        low_free = SW'(k);
      end
    end
  end

  assign can_push  = !out_valid_q || res_o.ready;
  assign last_slot = (idx_q == SW'(WINDOW_MAX - 1));
  assign ack_hit   = busy_q[idx_q] && (slot_rdata.pidx >= base_q) &&
                     (ack_q >= slot_rdata.exp_ack);
  assign pend_now  = pending_q || (slot_rdata.pidx == base_q);
  assign diff      = slot_rdata.pidx - base_q;
  assign freed_n   = freed_q + CW'(ack_hit);

  // Slot read address: scan index, or mapped slot during retransmission
  always_comb begin
    if (state_q == ST_RT_CHK || state_q == ST_RT_EV) begin
      slot_raddr = map_slot_q[pos_q[SW-1:0]];
    end else begin
      slot_raddr = idx_q;
    end
  end

  // Sequencer: next state, counters, memory writes and result staging
  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    base_d      = base_q;
    next_pidx_d = next_pidx_q;
    byte_cnt_d  = byte_cnt_q;
    q_head_d    = q_head_q;
    q_tail_d    = q_tail_q;
    q_count_d   = q_count_q;
    seg_len_d   = seg_len_q;
    seg_fin_d   = seg_fin_q;
    ack_d       = ack_q;
    retx_d      = retx_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    freed_d     = freed_q;
    pending_d   = pending_q;
    map_v_d     = map_v_q;
    map_slot_d  = map_slot_q;
    rs_valid_d  = rs_valid_q;
    rs_d        = rs_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    slot_we     = 1'b0;
    slot_waddr  = low_free;
    slot_wdata  = '{pidx: next_pidx_q, exp_ack: byte_cnt_q + 32'(seg_len_q),
                    seq: byte_cnt_q, len: seg_len_q, fin: seg_fin_q};
    q_we        = 1'b0;
    q_wdata     = '{len: seg_len_q, fin: seg_fin_q};
    snd_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (snd_i.valid) begin
          seg_len_d = snd_i.seg_len;
          seg_fin_d = snd_i.seg_fin;
          ack_d     = snd_i.ack_value;
          idx_d     = '0;
          pos_d     = '0;
          freed_d   = '0;
          pending_d = 1'b0;
          map_v_d   = '0;
          retx_d    = 1'b0;
          unique case (cmd_e'(snd_i.command))
            CMD_SEND:    state_d = ST_SEND;
            CMD_ACK:     state_d = ST_ACK_RD;
            CMD_TIMEOUT: begin
              state_d = ST_TO_RD;
              retx_d  = 1'b1;
            end
            default:     state_d = ST_IDLE;
          endcase
        end
      end

      ST_SEND: begin
        rs_valid_d = 1'b1;
        if (busy_cnt < ws_eff) begin
          slot_we           = 1'b1;
          busy_d[low_free]  = 1'b1;
          next_pidx_d       = next_pidx_q + 32'd1;
          byte_cnt_d        = byte_cnt_q + 32'(seg_len_q);
          rs_d = '{action: ACT_TX_NEW, packet_number: next_pidx_q, byte_seq: byte_cnt_q,
                   data_len: seg_len_q, fin_flag: seg_fin_q,
                   restart_timer: (next_pidx_q == base_q), last: 1'b0};
        end else if (32'(q_count_q) < 32'(QUEUE_DEPTH)) begin
          q_we      = 1'b1;
          q_tail_d  = (q_tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_q + QW'(1);
          q_count_d = q_count_q + QCW'(1);
          rs_d = '{action: ACT_QUEUED, packet_number: 32'd0, byte_seq: 32'd0,
                   data_len: seg_len_q, fin_flag: seg_fin_q, restart_timer: 1'b0,
                   last: 1'b0};
        end else begin
          rs_d = '{action: ACT_DROPPED, packet_number: 32'd0, byte_seq: 32'd0,
                   data_len: seg_len_q, fin_flag: seg_fin_q, restart_timer: 1'b0,
                   last: 1'b0};
        end
        state_d = ST_FIN;
      end

      ST_ACK_RD: state_d = ST_ACK_EV;

      ST_ACK_EV: begin
        // Hold while a released segment cannot be staged
        if (!(ack_hit && q_count_q != '0 && rs_valid_q && !can_push)) begin
          if (ack_hit) begin
            busy_d[idx_q] = 1'b0;
            freed_d       = freed_n;
            pending_d     = pend_now;
            if (q_count_q != '0) begin
              if (rs_valid_q) begin
                out_valid_d = 1'b1;
                out_d       = rs_q;
              end
              slot_we          = 1'b1;
              slot_wdata       = '{pidx: next_pidx_q,
                                   exp_ack: byte_cnt_q + 32'(q_rdata.len),
                                   seq: byte_cnt_q, len: q_rdata.len, fin: q_rdata.fin};
              busy_d[low_free] = 1'b1;
              next_pidx_d      = next_pidx_q + 32'd1;
              byte_cnt_d       = byte_cnt_q + 32'(q_rdata.len);
              q_count_d        = q_count_q - QCW'(1);
              q_head_d   = (q_head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + QW'(1);
              rs_valid_d = 1'b1;
              rs_d = '{action: ACT_TX_DEQ, packet_number: next_pidx_q,
                       byte_seq: byte_cnt_q, data_len: q_rdata.len,
                       fin_flag: q_rdata.fin, restart_timer: pend_now, last: 1'b0};
              pending_d  = 1'b0;
            end
          end
          if (last_slot) begin
            base_d  = base_q + 32'(freed_n);
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q + SW'(1);
            state_d = ST_ACK_RD;
          end
        end
      end

      ST_TO_RD: state_d = ST_TO_EV;

      ST_TO_EV: begin
        // Map each busy slot in the window to its position from base
        if (busy_q[idx_q] && diff < 32'(ws_eff) && !map_v_q[diff[SW-1:0]]) begin
          map_v_d[diff[SW-1:0]]    = 1'b1;
          map_slot_d[diff[SW-1:0]] = idx_q;
        end
        if (last_slot) begin
          state_d = ST_RT_CHK;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = ST_TO_RD;
        end
      end

      ST_RT_CHK: begin
        if (pos_q >= ws_eff) begin
          state_d = ST_FIN;
        end else if (map_v_q[pos_q[SW-1:0]]) begin
          state_d = ST_RT_EV;
        end else begin
          pos_d = pos_q + CW'(1);
        end
      end

      ST_RT_EV: begin
        if (!(rs_valid_q && !can_push)) begin
          if (rs_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = rs_q;
          end
          rs_valid_d = 1'b1;
          rs_d = '{action: ACT_RETX, packet_number: base_q + 32'(pos_q),
                   byte_seq: slot_rdata.seq, data_len: slot_rdata.len,
                   fin_flag: slot_rdata.fin, restart_timer: 1'b0, last: 1'b0};
          pos_d   = pos_q + CW'(1);
          state_d = ST_RT_CHK;
        end
      end

      ST_FIN: begin
        // Flush the staged result as the last one of the command
        if (!rs_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_push) begin
          out_valid_d = 1'b1;
          out_d       = rs_q;
          out_d.last  = 1'b1;
          if (retx_q) begin
            out_d.restart_timer = 1'b1;
          end
          rs_valid_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_reg_q   <= WIN_SIZE_RESET;
      busy_q      <= '0;
      base_q      <= '0;
      next_pidx_q <= '0;
      byte_cnt_q  <= '0;
      q_head_q    <= '0;
      q_tail_q    <= '0;
      q_count_q   <= '0;
      rs_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      map_v_q     <= '0;
      pending_q   <= 1'b0;
      freed_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      retx_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        win_reg_q <= cfg_wdata_i;
      end
      busy_q      <= busy_d;
      base_q      <= base_d;
      next_pidx_q <= next_pidx_d;
      byte_cnt_q  <= byte_cnt_d;
      q_head_q    <= q_head_d;
      q_tail_q    <= q_tail_d;
      q_count_q   <= q_count_d;
      rs_valid_q  <= rs_valid_d;
      out_valid_q <= out_valid_d;
      map_v_q     <= map_v_d;
      pending_q   <= pending_d;
      freed_q     <= freed_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      retx_q      <= retx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    seg_len_q  <= seg_len_d;
    seg_fin_q  <= seg_fin_d;
    ack_q      <= ack_d;
    map_slot_q <= map_slot_d;
    rs_q       <= rs_d;
    out_q      <= out_d;
  end

  // Drive the result channel
  assign res_o.valid         = out_valid_q;
  assign res_o.action        = out_q.action;
  assign res_o.packet_number = out_q.packet_number;
  assign res_o.byte_seq      = out_q.byte_seq;
  assign res_o.data_len      = out_q.data_len;
  assign res_o.fin_flag      = out_q.fin_flag;
  assign res_o.restart_timer = out_q.restart_timer;
  assign res_o.last          = out_q.last;

`ifndef SYNTH
  a_qcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_count_q) <= 32'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_qempty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count_q == '0) |-> (q_head_q == q_tail_q))
    else $error("empty queue with unequal pointers");

  a_stage_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rs_valid_q)
    else $error("staged result left behind at idle");

  a_fin_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && rs_valid_q && can_push) |=> (out_valid_q && out_q.last))
    else $error("final result not marked last");
`endif

endmodule
